@@ src/ebs_pkg.sv @@
// Shared constants, types and state encodings of the eigenvalue bisection search.
`timescale 1ns / 1ps
package ebs_pkg;

    localparam int XW        = 32;          // Q16.16 word
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 6;           // point and root counts
    localparam int STEP_W    = 4;           // halving count and determinant step
    localparam int IDX_W     = 3;           // register index
    localparam int MAX_HALVINGS = 12;

    localparam int D_W   = XW + 1;          // diagonal term entry - x
    localparam int CW    = 2 * D_W + 1;     // 2x2 cofactor
    localparam int LO_W  = D_W;             // low slice of a cofactor
    localparam int MA_W  = CW - LO_W;       // multiplier operand A
    localparam int MB_W  = D_W;             // multiplier operand B
    localparam int MP_W  = MA_W + MB_W;     // product
    localparam int DW    = MP_W + LO_W;     // determinant
    localparam int ACC_W = D_W + CNT_W;     // |span| * i
    localparam int QW    = XW + FRAC_BITS;  // divider dividend and quotient
    localparam int T_W   = FRAC_BITS + 1;   // secant weight
    localparam int DET_LAST = 12;           // last step of one determinant

    localparam logic signed [XW-1:0] E00_RST = 32'sd150733;
    localparam logic signed [XW-1:0] E01_RST = 32'sd439091;
    localparam logic signed [XW-1:0] E02_RST = 32'sd511181;
    localparam logic signed [XW-1:0] E11_RST = 32'sd229376;
    localparam logic signed [XW-1:0] E12_RST = 32'sd98304;
    localparam logic signed [XW-1:0] E22_RST = 32'sd144179;
    localparam logic [STEP_W-1:0]    STEPS_RST = 4'd10;

    localparam logic [1:0] STATUS_ROOT = 2'd0;
    localparam logic [1:0] STATUS_NONE = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;

    typedef enum logic [IDX_W-1:0] {
        REG_E00, REG_E01, REG_E02, REG_E11, REG_E12, REG_E22, REG_STEPS
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIRST, ST_FIRST_W, ST_NEXT, ST_DIV_W, ST_DET_PT, ST_DET_PT_W,
        ST_CHECK, ST_BIS, ST_BIS_W, ST_NORM, ST_SEC_DIV_W, ST_SEC_FIN,
        ST_EMIT_ROOT, ST_FINAL
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_DET_PREV, OP_TAKE_Y1, OP_ADVANCE, OP_TAKE_XI,
        OP_DET_XI, OP_TAKE_Y2, OP_SHIFT, OP_ROOT_PREV, OP_ROOT_XI, OP_BIS_INIT,
        OP_DET_MID, OP_BIS_UPD, OP_ROOT_MID, OP_MAG_LOAD, OP_NORM_SHIFT,
        OP_SEC_DIV, OP_SEC_MUL, OP_SEC_FIN, OP_EMIT_ROOT, OP_EMIT_FINAL
    } t_op;

    typedef struct packed {
        logic det_done;
        logic div_done;
        logic y1_zero;
        logic y2_zero;
        logic sign_diff;
        logic pts_done;
        logic iter_done;
        logic mid_zero;
        logic norm_done;
        logic out_free;
    } t_stat;

endpackage

@@ src/ebs_req_if.sv @@
// Request channel: search range and point count.
`timescale 1ns / 1ps
interface ebs_req_if;
    import ebs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [XW-1:0]   range_low;
    logic signed [XW-1:0]   range_high;
    logic [CNT_W-1:0]       point_count;
    modport source (output valid, range_low, range_high, point_count, input ready);
    modport sink   (input valid, range_low, range_high, point_count, output ready);
endinterface

@@ src/ebs_res_if.sv @@
// Result channel: one word per root found and a closing word.
`timescale 1ns / 1ps
interface ebs_res_if;
    import ebs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic signed [XW-1:0]   root_value;
    logic signed [XW-1:0]   interval_start;
    logic signed [XW-1:0]   interval_end;
    logic [CNT_W-1:0]       root_count;
    logic                   last;
    modport source (output valid, status, root_value, interval_start, interval_end,
                    root_count, last, input ready);
    modport sink   (input valid, status, root_value, interval_start, interval_end,
                    root_count, last, output ready);
endinterface

@@ src/ebs_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ebs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ebs_pkg::QW-1:0]           i_dividend,
    input  logic [ebs_pkg::XW-1:0]           i_divisor,
    output logic [ebs_pkg::QW-1:0]           o_quotient,
    output logic                             o_done
);
    import ebs_pkg::*;

    localparam int CW_DIV = $clog2(QW);

    logic [XW-1:0]     r_rem;
    logic [XW-1:0]     r_dsr;
    logic [QW-1:0]     r_quo;
    logic [CW_DIV-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [XW:0]       w_rem_sh;
    logic              w_fit;

    assign w_rem_sh = {r_rem, r_quo[QW-1]};
    assign w_fit    = w_rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW_DIV'(QW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW_DIV'(QW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? XW'(w_rem_sh - {1'b0, r_dsr}) : XW'(w_rem_sh);
            r_quo <= {r_quo[QW-2:0], w_fit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ src/ebs_dpath.sv @@
// Datapath: matrix registers, determinant sequencer, divider, bracket and output registers.
`timescale 1ns / 1ps
module ebs_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ebs_pkg::t_op                     i_op,
    output ebs_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_wr_en,
    input  logic [ebs_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [ebs_pkg::XW-1:0]           i_cfg_data,
    input  logic signed [ebs_pkg::XW-1:0]    i_range_low,
    input  logic signed [ebs_pkg::XW-1:0]    i_range_high,
    input  logic [ebs_pkg::CNT_W-1:0]        i_point_count,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [1:0]                       o_status,
    output logic signed [ebs_pkg::XW-1:0]    o_root_value,
    output logic signed [ebs_pkg::XW-1:0]    o_interval_start,
    output logic signed [ebs_pkg::XW-1:0]    o_interval_end,
    output logic [ebs_pkg::CNT_W-1:0]        o_root_count,
    output logic                             o_last
);
    import ebs_pkg::*;

    // matrix and halving count
    logic signed [XW-1:0] r_e00, r_e01, r_e02, r_e11, r_e12, r_e22;
    logic [STEP_W-1:0]    r_steps;
    logic [STEP_W-1:0]    w_nb;

    // search state
    logic signed [XW-1:0] r_lo, r_hi, r_prev, r_xi, r_xl, r_xu, r_xm, r_root;
    logic [CNT_W-1:0]     r_n, r_i, r_count;
    logic [D_W-1:0]       r_span_mag;
    logic                 r_span_neg;
    logic [ACC_W-1:0]     r_acc;
    logic signed [DW-1:0] r_y1, r_y2, r_fl, r_fu;
    logic [DW-1:0]        r_ml, r_mu;
    logic [STEP_W-1:0]    r_iter;

    // determinant sequencer
    logic signed [D_W-1:0]  r_d0, r_d1, r_d2;
    logic signed [CW-1:0]   r_c0, r_c1, r_c2;
    logic signed [DW-1:0]   r_det;
    logic signed [MP_W-1:0] r_prod;
    logic [STEP_W-1:0]      r_dstep;
    logic                   r_dbusy;
    logic                   r_det_done;

    // output register
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic signed [XW-1:0] r_o_root, r_o_start, r_o_end;
    logic [CNT_W-1:0]     r_o_count;
    logic                 r_o_last;

    logic signed [D_W-1:0]  w_span, w_xdiff, w_xd_rnd, w_mid_full;
    logic signed [XW-1:0]   w_mid, w_det_x, w_xi;
    logic                   w_det_start;
    logic [ACC_W-1:0]       w_acc_next;
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    logic signed [MP_W-1:0] w_mul, w_rnd, w_sec;
    logic signed [DW-1:0]   w_p_ext, w_p_sh;
    logic [XW-1:0]          w_den;
    logic                   w_div_start, w_div_done;
    logic [QW-1:0]          w_div_a, w_quo;
    logic [XW-1:0]          w_div_b;
    logic signed [D_W:0]    w_qs, w_xi_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e00 <= E00_RST; r_e01 <= E01_RST; r_e02 <= E02_RST;
            r_e11 <= E11_RST; r_e12 <= E12_RST; r_e22 <= E22_RST;
            r_steps <= STEPS_RST;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_E00:   r_e00 <= i_cfg_data;
                REG_E01:   r_e01 <= i_cfg_data;
                REG_E02:   r_e02 <= i_cfg_data;
                REG_E11:   r_e11 <= i_cfg_data;
                REG_E12:   r_e12 <= i_cfg_data;
                REG_E22:   r_e22 <= i_cfg_data;
                REG_STEPS: r_steps <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_nb = (r_steps > STEP_W'(MAX_HALVINGS)) ? STEP_W'(MAX_HALVINGS) : r_steps;

    // x arithmetic
    assign w_span     = D_W'(i_range_high) - D_W'(i_range_low);
    assign w_xdiff    = D_W'(r_xu) - D_W'(r_xl);
    assign w_xd_rnd   = w_xdiff + $signed({{XW{1'b0}}, w_xdiff[XW]});
    assign w_mid_full = D_W'(r_xl) + (w_xd_rnd >>> 1);
    assign w_mid      = w_mid_full[XW-1:0];
    assign w_acc_next = r_acc + ACC_W'(r_span_mag);
    assign w_qs       = r_span_neg ? -$signed({1'b0, w_quo[D_W-1:0]})
                                   :  $signed({1'b0, w_quo[D_W-1:0]});
    assign w_xi_full  = (D_W + 1)'(r_lo) + w_qs;
    assign w_xi       = w_xi_full[XW-1:0];
    assign w_den      = XW'(r_ml[XW-2:0]) + XW'(r_mu[XW-2:0]);
    assign w_rnd      = r_prod + $signed({{(MP_W-FRAC_BITS){1'b0}},
                                          {FRAC_BITS{r_prod[MP_W-1]}}});
    assign w_sec      = MP_W'(r_xl) + (w_rnd >>> FRAC_BITS);

    // divider: sample points and secant weight
    assign w_div_start = (i_op == OP_ADVANCE) || (i_op == OP_SEC_DIV);
    assign w_div_a = (i_op == OP_ADVANCE) ? QW'(w_acc_next)
                                          : {1'b0, r_ml[XW-2:0], {FRAC_BITS{1'b0}}};
    assign w_div_b = (i_op == OP_ADVANCE) ? XW'(r_n) : w_den;

    ebs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // determinant start
    always_comb begin
        w_det_start = 1'b1;
        case (i_op)
            OP_DET_PREV: w_det_x = r_prev;
            OP_DET_XI:   w_det_x = r_xi;
            OP_DET_MID:  w_det_x = w_mid;
            default: begin
                w_det_x     = r_prev;
                w_det_start = 1'b0;
            end
        endcase
    end

    // shared multiplier: cofactor schedule while busy, secant product otherwise
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_dbusy) begin
            case (r_dstep)
                4'd0:  begin w_ma = MA_W'(r_d1);  w_mb = r_d2;        end
                4'd1:  begin w_ma = MA_W'(r_e12); w_mb = MB_W'(r_e12); end
                4'd2:  begin w_ma = MA_W'(r_e01); w_mb = r_d2;        end
                4'd3:  begin w_ma = MA_W'(r_e12); w_mb = MB_W'(r_e02); end
                4'd4:  begin w_ma = MA_W'(r_e01); w_mb = MB_W'(r_e12); end
                4'd5:  begin w_ma = MA_W'(r_d1);  w_mb = MB_W'(r_e02); end
                4'd6:  begin w_ma = $signed({1'b0, r_c0[LO_W-1:0]}); w_mb = r_d0; end
                4'd7:  begin w_ma = r_c0[CW-1:LO_W]; w_mb = r_d0; end
                4'd8:  begin w_ma = $signed({1'b0, r_c1[LO_W-1:0]}); w_mb = MB_W'(r_e01); end
                4'd9:  begin w_ma = r_c1[CW-1:LO_W]; w_mb = MB_W'(r_e01); end
                4'd10: begin w_ma = $signed({1'b0, r_c2[LO_W-1:0]}); w_mb = MB_W'(r_e02); end
                4'd11: begin w_ma = r_c2[CW-1:LO_W]; w_mb = MB_W'(r_e02); end
                default: ;
            endcase
        end else begin
            w_ma = MA_W'(w_xdiff);
            w_mb = (w_den == '0) ? '0 : $signed({{(MB_W-T_W){1'b0}}, w_quo[T_W-1:0]});
        end
    end

    assign w_mul   = w_ma * w_mb;
    assign w_p_ext = DW'(r_prod);
    assign w_p_sh  = DW'(r_prod) <<< LO_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy    <= 1'b0;
            r_det_done <= 1'b0;
        end else begin
            r_det_done <= r_dbusy && (r_dstep == STEP_W'(DET_LAST));
            if (w_det_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && (r_dstep == STEP_W'(DET_LAST))) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        if (w_det_start) begin
            r_d0    <= D_W'(r_e00) - D_W'(w_det_x);
            r_d1    <= D_W'(r_e11) - D_W'(w_det_x);
            r_d2    <= D_W'(r_e22) - D_W'(w_det_x);
            r_dstep <= '0;
        end else if (r_dbusy) begin
            r_dstep <= r_dstep + 1'b1;
            // fold in the product of the previous step
            case (r_dstep)
                4'd1:  r_c0  <= r_prod;
                4'd2:  r_c0  <= r_c0 - r_prod;
                4'd3:  r_c1  <= r_prod;
                4'd4:  r_c1  <= r_c1 - r_prod;
                4'd5:  r_c2  <= r_prod;
                4'd6:  r_c2  <= r_c2 - r_prod;
                4'd7:  r_det <= w_p_ext;
                4'd8:  r_det <= r_det + w_p_sh;
                4'd9:  r_det <= r_det - w_p_ext;
                4'd10: r_det <= r_det - w_p_sh;
                4'd11: r_det <= r_det + w_p_ext;
                4'd12: r_det <= r_det + w_p_sh;
                default: ;
            endcase
        end
    end

    // search and bracket registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_lo       <= i_range_low;
                r_hi       <= i_range_high;
                r_n        <= i_point_count;
                r_span_neg <= w_span[XW];
                r_span_mag <= w_span[XW] ? D_W'(-w_span) : D_W'(w_span);
                r_acc      <= '0;
                r_i        <= '0;
                r_prev     <= i_range_low;
                r_count    <= '0;
            end
            OP_TAKE_Y1: r_y1 <= r_det;
            OP_ADVANCE: begin
                r_i   <= r_i + 1'b1;
                r_acc <= w_acc_next;
            end
            OP_TAKE_XI:   r_xi <= w_xi;
            OP_TAKE_Y2:   r_y2 <= r_det;
            OP_SHIFT: begin
                r_y1   <= r_y2;
                r_prev <= r_xi;
            end
            OP_ROOT_PREV: r_root <= r_prev;
            OP_ROOT_XI:   r_root <= r_xi;
            OP_ROOT_MID:  r_root <= r_xm;
            OP_BIS_INIT: begin
                r_xl   <= r_prev;
                r_xu   <= r_xi;
                r_fl   <= r_y1;
                r_fu   <= r_y2;
                r_iter <= '0;
            end
            OP_DET_MID:   r_xm <= w_mid;
            OP_BIS_UPD: begin
                if (r_det[DW-1] == r_fu[DW-1]) begin
                    r_xu <= r_xm;
                    r_fu <= r_det;
                end else begin
                    r_xl <= r_xm;
                    r_fl <= r_det;
                end
                r_iter <= r_iter + 1'b1;
            end
            OP_MAG_LOAD: begin
                r_ml <= r_fl[DW-1] ? DW'(-r_fl) : DW'(r_fl);
                r_mu <= r_fu[DW-1] ? DW'(-r_fu) : DW'(r_fu);
            end
            OP_NORM_SHIFT: begin
                r_ml <= r_ml >> 1;
                r_mu <= r_mu >> 1;
            end
            OP_SEC_FIN:   r_root <= w_sec[XW-1:0];
            OP_EMIT_ROOT: begin
                r_count <= r_count + 1'b1;
                r_y1    <= r_y2;
                r_prev  <= r_xi;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_op == OP_EMIT_ROOT) || (i_op == OP_EMIT_FINAL)) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT_ROOT) begin
            r_status  <= STATUS_ROOT;
            r_o_root  <= r_root;
            r_o_start <= r_prev;
            r_o_end   <= r_xi;
            r_o_count <= r_count + 1'b1;
            r_o_last  <= 1'b0;
        end else if (i_op == OP_EMIT_FINAL) begin
            r_status  <= STATUS_DONE;
            r_o_root  <= '0;
            r_o_start <= r_lo;
            r_o_end   <= r_hi;
            r_o_count <= r_count;
            r_o_last  <= 1'b1;
        end
    end

    assign o_stat.det_done  = r_det_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.y1_zero   = (r_y1 == '0);
    assign o_stat.y2_zero   = (r_y2 == '0);
    assign o_stat.sign_diff = r_y1[DW-1] != r_y2[DW-1];
    assign o_stat.pts_done  = (r_i == r_n);
    assign o_stat.iter_done = (r_iter == w_nb);
    assign o_stat.mid_zero  = (r_det == '0);
    assign o_stat.norm_done = (r_ml[DW-1:XW-1] == '0) && (r_mu[DW-1:XW-1] == '0);
    assign o_stat.out_free  = !r_out_valid || i_res_ready;

    assign o_res_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_root_value     = r_o_root;
    assign o_interval_start = r_o_start;
    assign o_interval_end   = r_o_end;
    assign o_root_count     = r_o_count;
    assign o_last           = r_o_last;

endmodule

@@ src/ebs_ctrl.sv @@
// Controller state machine: sequences sampling, bracketing, halving and secant steps.
`timescale 1ns / 1ps
module ebs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ebs_pkg::t_stat  i_stat,
    output ebs_pkg::t_op    o_op
);
    import ebs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_req_valid) n_state = ST_FIRST;
            ST_FIRST:     n_state = ST_FIRST_W;
            ST_FIRST_W:   if (i_stat.det_done) n_state = ST_NEXT;
            ST_NEXT:      n_state = i_stat.pts_done ? ST_FINAL : ST_DIV_W;
            ST_DIV_W:     if (i_stat.div_done) n_state = ST_DET_PT;
            ST_DET_PT:    n_state = ST_DET_PT_W;
            ST_DET_PT_W:  if (i_stat.det_done) n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_stat.y1_zero || i_stat.y2_zero) begin
                    n_state = ST_EMIT_ROOT;
                end else if (i_stat.sign_diff) begin
                    n_state = ST_BIS;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_BIS:       n_state = i_stat.iter_done ? ST_NORM : ST_BIS_W;
            ST_BIS_W: begin
                if (i_stat.det_done) begin
                    n_state = i_stat.mid_zero ? ST_EMIT_ROOT : ST_BIS;
                end
            end
            ST_NORM:      if (i_stat.norm_done) n_state = ST_SEC_DIV_W;
            ST_SEC_DIV_W: if (i_stat.div_done) n_state = ST_SEC_FIN;
            ST_SEC_FIN:   n_state = ST_EMIT_ROOT;
            ST_EMIT_ROOT: if (i_stat.out_free) n_state = ST_NEXT;
            ST_FINAL:     if (i_stat.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op        = OP_NOP;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) o_op = OP_LOAD;
            end
            ST_FIRST:     o_op = OP_DET_PREV;
            ST_FIRST_W:   if (i_stat.det_done) o_op = OP_TAKE_Y1;
            ST_NEXT:      if (!i_stat.pts_done) o_op = OP_ADVANCE;
            ST_DIV_W:     if (i_stat.div_done) o_op = OP_TAKE_XI;
            ST_DET_PT:    o_op = OP_DET_XI;
            ST_DET_PT_W:  if (i_stat.det_done) o_op = OP_TAKE_Y2;
            ST_CHECK: begin
                if (i_stat.y1_zero) begin
                    o_op = OP_ROOT_PREV;
                end else if (i_stat.y2_zero) begin
                    o_op = OP_ROOT_XI;
                end else if (i_stat.sign_diff) begin
                    o_op = OP_BIS_INIT;
                end else begin
                    o_op = OP_SHIFT;
                end
            end
            ST_BIS:       o_op = i_stat.iter_done ? OP_MAG_LOAD : OP_DET_MID;
            ST_BIS_W: begin
                if (i_stat.det_done) o_op = i_stat.mid_zero ? OP_ROOT_MID : OP_BIS_UPD;
            end
            ST_NORM:      o_op = i_stat.norm_done ? OP_SEC_DIV : OP_NORM_SHIFT;
            ST_SEC_DIV_W: if (i_stat.div_done) o_op = OP_SEC_MUL;
            ST_SEC_FIN:   o_op = OP_SEC_FIN;
            ST_EMIT_ROOT: if (i_stat.out_free) o_op = OP_EMIT_ROOT;
            ST_FINAL:     if (i_stat.out_free) o_op = OP_EMIT_FINAL;
            default: ;
        endcase
    end

endmodule

@@ src/eigenvalue_bisection_search_core.sv @@
// Top level of the eigenvalue search by bisection of det(A - xI) for a symmetric 3x3 matrix.
`timescale 1ns / 1ps
// Usage:
//   i_req carries one search word (range_low, range_high, point_count). It is
//   taken only while the core is idle; one search runs at a time.
//   o_res carries one word per bracketed root (status 0, root, bracket ends,
//   running root count), then a closing word with status 2, the range, the
//   total count and last set.
//   The config port writes the six Q16.16 matrix entries and the halving count
//   (index 0..6); other indexes are dropped. The user must write them only while
//   no search is running; the core does not enforce this.
// Steps:
//   one determinant is issued, then built on the shared 34x33 multiplier; each
//   sample point adds a 48-step divide for its x. Per root come the halvings, each
//   one determinant, then normalizing shifts and a 48-step divide for the secant
//   weight.
// Reset clears the controller, the output valid and loads the default matrix.
// When the receiver stalls, the finished word waits in the output register
// and the search holds at the next emit until that register frees.
module eigenvalue_bisection_search_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ebs_req_if.sink                    i_req,
    ebs_res_if.source                  o_res,
    input  logic                       i_cfg_wr_en,
    input  logic [ebs_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [ebs_pkg::XW-1:0]     i_cfg_data
);
    import ebs_pkg::*;

    t_op   w_op;
    t_stat w_stat;
    logic  w_req_ready;

    // controller: walks the points and brackets, hands one op per cycle
    ebs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_op        (w_op)
    );

    assign i_req.ready = w_req_ready;

    // datapath: matrix, determinant, divider and result register
    ebs_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .o_stat           (w_stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_range_low      (i_req.range_low),
        .i_range_high     (i_req.range_high),
        .i_point_count    (i_req.point_count),
        .o_res_valid      (o_res.valid),
        .i_res_ready      (o_res.ready),
        .o_status         (o_res.status),
        .o_root_value     (o_res.root_value),
        .o_interval_start (o_res.interval_start),
        .o_interval_end   (o_res.interval_end),
        .o_root_count     (o_res.root_count),
        .o_last           (o_res.last)
    );

endmodule
